/* hdl/swm_pkg.sv */
// Shared types and constants for the sliding window maximum block.
// Used by swm_cell, swm_deque and sliding_window_maximum; no dependencies.
package swm_pkg;

    localparam int DATA_W = 32;
    localparam int WS_W   = 7;

    // Entry state one cell hands toward the deque head
    typedef struct packed {
        logic                     vld;
        logic                     ge;
        logic signed [DATA_W-1:0] val;
    } swm_entry_t;

    // Controls broadcast to every cell
    typedef struct packed {
        logic                     en;
        logic                     clear;
        logic                     shift;
        logic signed [DATA_W-1:0] sample;
    } swm_ctl_t;

endpackage

/* hdl/swm_cell.sv */
// One deque cell: holds a candidate maximum and its valid flag.
// Depends on swm_pkg for the entry and control structs.
module swm_cell
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  swm_pkg::swm_ctl_t                      ctl,
    input  swm_pkg::swm_entry_t                    from_right,
    input  logic                                   prev_keep,
    output swm_pkg::swm_entry_t                    own,
    output logic                                   src_keep,
    output logic signed [swm_pkg::DATA_W-1:0]      val_next
);

    logic                                  vld_reg;
    logic signed [swm_pkg::DATA_W-1:0]     val_reg;
    logic                                  vld_next;
    swm_pkg::swm_entry_t                   src;

    always_comb
    begin
        own.vld = vld_reg & ~ctl.clear;
        own.ge  = (val_reg >= ctl.sample);
        own.val = val_reg;
    end

    // Take the neighbor's entry when the head is dropped, keep it if not below the sample
    always_comb
    begin
        src      = ctl.shift ? from_right : own;
        src_keep = src.vld & src.ge;
        vld_next = src_keep | prev_keep;
        val_next = src_keep ? src.val : ctl.sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            val_reg <= val_next;
        end
    end

endmodule

/* hdl/swm_deque.sv */
// Monotonic deque of candidate maxima built as a row of swm_cell instances.
// Depends on swm_pkg and swm_cell.
module swm_deque #(
    parameter int DEPTH = 64
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   clear,
    input  logic                                   drop,
    input  logic signed [swm_pkg::DATA_W-1:0]      sample,
    output swm_pkg::swm_entry_t                    head,
    output logic signed [swm_pkg::DATA_W-1:0]      head_next
);

    swm_pkg::swm_entry_t                 own [DEPTH];
    logic                                keep [DEPTH];
    logic signed [swm_pkg::DATA_W-1:0]   nxt [DEPTH];
    swm_pkg::swm_ctl_t                   ctl;
    logic                                full;

    // A full deque that keeps every entry loses its head to make room
    assign full = own[DEPTH-1].vld & own[DEPTH-1].ge & ~drop;

    always_comb
    begin
        ctl.en     = en;
        ctl.clear  = clear;
        ctl.shift  = drop | full;
        ctl.sample = sample;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            swm_pkg::swm_entry_t right;
            logic                prev;

            if (i == DEPTH - 1)
            begin : g_last
                assign right = '0;
            end
            else
            begin : g_mid
                assign right = own[i+1];
            end

            if (i == 0)
            begin : g_head
                assign prev = 1'b1;
            end
            else
            begin : g_tail
                assign prev = keep[i-1];
            end

            swm_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .from_right (right),
                .prev_keep  (prev),
                .own        (own[i]),
                .src_keep   (keep[i]),
                .val_next   (nxt[i])
            );
        end
    endgenerate

    assign head      = own[0];
    assign head_next = nxt[0];

endmodule

/* hdl/sliding_window_maximum.sv */
// Each input transfer registers the sample and the ring entry leaving the window; the result
// is registered once the previous result is taken, and only then is a new sample accepted.
// The deque cells update in parallel in the update state, so the rate is independent of size.
// Reset: asynchronous active low; empties the deque, clears fill count and ring pointer,
// sets window_size to 1. Ring and deque contents are not cleared; no clearing pass.
// Top level: sliding window maximum; depends on swm_pkg and swm_deque.
module sliding_window_maximum #(
    parameter int WINDOW_MAX = 64
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [swm_pkg::WS_W-1:0]               window_size,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [swm_pkg::DATA_W-1:0]      sample,
    input  logic                                   restart,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [swm_pkg::DATA_W-1:0]      window_max
);

    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int KW    = (CNT_W > swm_pkg::WS_W) ? CNT_W : swm_pkg::WS_W;
    localparam logic [KW-1:0]    W_K = KW'(WINDOW_MAX);
    localparam logic [CNT_W-1:0] W_C = CNT_W'(WINDOW_MAX);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } state_t;

    state_t                              state_reg, state_next;
    logic [swm_pkg::WS_W-1:0]            ws_reg;
    logic [CNT_W-1:0]                    fill_reg;
    logic [PTR_W-1:0]                    ptr_reg;
    logic signed [swm_pkg::DATA_W-1:0]   sample_reg;
    logic                                restart_reg;
    logic signed [swm_pkg::DATA_W-1:0]   leave_reg;
    logic                                out_valid_reg;
    logic signed [swm_pkg::DATA_W-1:0]   window_max_reg;

    logic signed [swm_pkg::DATA_W-1:0]   ring [WINDOW_MAX];

    logic [KW-1:0]                       ws_ext;
    logic [KW-1:0]                       k_full;
    logic [CNT_W-1:0]                    k;
    logic [CNT_W-1:0]                    ptr_c;
    logic [CNT_W-1:0]                    back;
    logic [PTR_W-1:0]                    ptr_eff;
    logic [CNT_W-1:0]                    ptr_inc;
    logic [PTR_W-1:0]                    ptr_next;
    logic [CNT_W-1:0]                    fill_eff;
    logic [CNT_W-1:0]                    fill_next;
    logic                                emit;
    logic                                go;
    logic                                drop;
    logic                                in_xfer;
    swm_pkg::swm_entry_t                 head;
    logic signed [swm_pkg::DATA_W-1:0]   head_next;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_xfer    = in_valid & in_ready;
    assign out_valid  = out_valid_reg;
    assign window_max = window_max_reg;
    assign go         = (state_reg == S_UPDATE) & (~out_valid_reg | out_ready);

    // Clamp the window size to 1..WINDOW_MAX
    always_comb
    begin
        ws_ext = KW'(ws_reg);
        if (ws_ext == '0)
        begin
            k_full = KW'(1);
        end
        else if (ws_ext > W_K)
        begin
            k_full = W_K;
        end
        else
        begin
            k_full = ws_ext;
        end
        k = k_full[CNT_W-1:0];
    end

    // Ring index of the sample leaving the window
    always_comb
    begin
        ptr_c = CNT_W'(ptr_reg);
        if (ptr_c >= k)
        begin
            back = ptr_c - k;
        end
        else
        begin
            back = ptr_c + (W_C - k);
        end
    end

    always_comb
    begin
        ptr_eff  = restart_reg ? '0 : ptr_reg;
        fill_eff = restart_reg ? '0 : fill_reg;
        ptr_inc  = CNT_W'(ptr_eff) + CNT_W'(1);
        ptr_next = (ptr_inc == W_C) ? '0 : ptr_inc[PTR_W-1:0];
        fill_next = (fill_eff < W_C) ? (fill_eff + CNT_W'(1)) : fill_eff;
        emit     = (fill_next >= k);
        drop     = (fill_eff >= k) & head.vld & (head.val == leave_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    swm_deque #(
        .DEPTH (WINDOW_MAX)
    ) u_deque
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (go),
        .clear     (restart_reg),
        .drop      (drop),
        .sample    (sample_reg),
        .head      (head),
        .head_next (head_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= swm_pkg::WS_W'(1);
            fill_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                ws_reg <= window_size;
            end
            if (go)
            begin
                fill_reg      <= fill_next;
                ptr_reg       <= ptr_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg  <= sample;
            restart_reg <= restart;
            leave_reg   <= ring[back[PTR_W-1:0]];
        end
        if (go)
        begin
            ring[ptr_eff] <= sample_reg;
            if (emit)
            begin
                window_max_reg <= head_next;
            end
        end
    end

endmodule

/* hdl/swm_checker.sv */
// Port-level checks for sliding_window_maximum, attached with a bind statement.
// Depends only on the top level's ports.
module swm_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [31:0]                     window_max
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(window_max))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample is in flight");

    a_result_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching input transfer");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && !(out_valid && !out_ready) |=> in_ready)
        else $error("input held off without a stalled result");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_max (window_max)
);

/* bench/sliding_window_maximum_tb.sv */
// Testbench for sliding_window_maximum: drives random and directed sample streams under
// random back-pressure and checks every window maximum against an in-bench deque predictor.
// Depends on swm_pkg and the sliding_window_maximum RTL.
module sliding_window_maximum_tb;

    localparam int DATA_W     = swm_pkg::DATA_W;
    localparam int WS_W       = swm_pkg::WS_W;
    localparam int DEPTH      = 64;
    localparam int HOLD_LEN   = 300;
    localparam int SETTLE_CYC = 8;
    localparam int LIST_LEN   = 4096;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     first;
    } stream_item_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [WS_W-1:0]          window_size = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] sample      = '0;
    logic                     restart     = 1'b0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic signed [DATA_W-1:0] window_max;

    // predictor state
    logic signed [DATA_W-1:0] hist_ring [DEPTH];
    logic signed [DATA_W-1:0] cand_list [DEPTH];
    int unsigned              cand_len;
    int unsigned              seen_len;
    int unsigned              wr_ptr;
    logic [WS_W-1:0]          win_reg;

    stream_item_t             pending_items [LIST_LEN];
    logic signed [DATA_W-1:0] max_expected [LIST_LEN];
    int                       pend_rd        = 0;
    int                       exp_wr         = 0;
    int                       exp_rd         = 0;
    stream_item_t             next_item;
    logic signed [DATA_W-1:0] exp_max;
    int                       queued_items   = 0;
    int                       accepted_items = 0;
    int                       errors         = 0;
    int                       send_gap       = 0;
    int                       stall_left     = 0;
    int                       hold_left      = 0;
    int                       hold_trigger   = 0;
    int                       hold_seen      = 0;
    bit                       idle_on        = 1'b1;
    int                       idle_pct       = 20;

    sliding_window_maximum #(.WINDOW_MAX(DEPTH)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .window_size (window_size),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .window_max  (window_max)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void drop_oldest_candidate();
        for (int i = 1; i < cand_len; i++)
        begin
            cand_list[i-1] = cand_list[i];
        end
        cand_len--;
    endfunction

    function automatic void predict_window_max(logic signed [DATA_W-1:0] s, logic first);
        int unsigned k;
        int unsigned idx;
        k = (win_reg == 0) ? 1 : ((win_reg > DEPTH) ? DEPTH : win_reg);
        if (first)
        begin
            cand_len = 0;
            seen_len = 0;
            wr_ptr   = 0;
        end
        if (seen_len >= k)
        begin
            idx = (wr_ptr + DEPTH - k) % DEPTH;
            if (cand_len > 0 && cand_list[0] == hist_ring[idx])
            begin
                drop_oldest_candidate();
            end
        end
        while (cand_len > 0 && s > cand_list[cand_len-1])
        begin
            cand_len--;
        end
        if (cand_len >= DEPTH)
        begin
            drop_oldest_candidate();
        end
        cand_list[cand_len] = s;
        cand_len++;
        hist_ring[wr_ptr] = s;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (seen_len < DEPTH)
        begin
            seen_len++;
        end
        if (seen_len >= k)
        begin
            max_expected[exp_wr] = cand_list[0];
            exp_wr++;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (sel < 8)
        begin
            return 32'sh8000_0000;
        end
        else if (sel < 11)
        begin
            return -32'sd1;
        end
        else if (sel < 50)
        begin
            return $signed($urandom_range(0, 15)) - 32'sd8;
        end
        return $signed($urandom);
    endfunction

    task automatic log_failure(input string msg);
        if (errors < 10)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        errors++;
    endtask

    task automatic push_item(input logic signed [DATA_W-1:0] value, input logic first);
        stream_item_t it;
        it.value = value;
        it.first = first;
        pending_items[queued_items] = it;
        queued_items++;
    endtask

    task automatic drain();
        while (queued_items != accepted_items || exp_wr != exp_rd)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_window(input logic [WS_W-1:0] ws);
        @(posedge clk);
        cfg_valid   <= 1'b1;
        window_size <= ws;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        win_reg = ws;
    endtask

    // stream driver: predict on each transfer, then present the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample   <= '0;
            restart  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_window_max(sample, restart);
                accepted_items++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pend_rd != queued_items)
                begin
                    if (idle_on && $urandom_range(0, 99) < idle_pct)
                    begin
                        send_gap = $urandom_range(1, 13) - 1;
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        next_item = pending_items[pend_rd];
                        pend_rd++;
                        sample   <= next_item.value;
                        restart  <= next_item.first;
                        in_valid <= 1'b1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result back-pressure: long hold on request, otherwise random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_LEN;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_wr == exp_rd)
            begin
                log_failure($sformatf("unexpected window_max %0d", window_max));
            end
            else
            begin
                exp_max = max_expected[exp_rd];
                exp_rd++;
                if (window_max !== exp_max)
                begin
                    log_failure($sformatf("window_max expected %0d actual %0d",
                                          exp_max, window_max));
                end
            end
        end
    end

    initial
    begin
        int               ph;
        int               i;
        int unsigned      pick;
        logic [WS_W-1:0]  ws;
        logic             first;

        cand_len = 0;
        seen_len = 0;
        wr_ptr   = 0;
        win_reg  = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window of one
        push_item(32'sd5, 1'b0);
        push_item(-32'sd3, 1'b0);
        push_item(32'sd9, 1'b0);
        drain();

        set_window(7'd3);
        push_item(32'sh7FFF_FFFF, 1'b1);
        push_item(32'sh8000_0000, 1'b0);
        push_item(32'sd0, 1'b0);
        push_item(-32'sd1, 1'b0);
        push_item(32'sh7FFF_FFFF, 1'b0);
        push_item(32'sh7FFF_FFFF, 1'b0);
        push_item(32'sh8000_0000, 1'b0);
        push_item(32'sh8000_0000, 1'b0);
        push_item(32'sh8000_0000, 1'b0);
        // short sequence, then a fresh one
        push_item(32'sd7, 1'b1);
        push_item(32'sd8, 1'b0);
        push_item(32'sd4, 1'b1);
        push_item(32'sd4, 1'b0);
        push_item(32'sd2, 1'b0);
        push_item(32'sd4, 1'b0);
        drain();

        set_window(7'd0);
        push_item(-32'sd20, 1'b1);
        push_item(32'sd20, 1'b0);
        push_item(32'sd1, 1'b0);
        drain();

        // fill the deque with a falling run, then shrink the window mid-sequence
        set_window(7'd127);
        for (i = 0; i < DEPTH + 2; i++)
        begin
            push_item(32'sd1000 - i * 7, i == 0);
        end
        drain();
        set_window(7'd1);
        for (i = 0; i < 3; i++)
        begin
            push_item(32'sd100 - i, 1'b0);
        end
        drain();

        for (ph = 0; ph < 16; ph++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                ws = $urandom_range(1, 12);
            end
            else if (pick < 7)
            begin
                ws = $urandom_range(13, 63);
            end
            else if (pick == 7)
            begin
                ws = 7'd64;
            end
            else if (pick == 8)
            begin
                ws = $urandom_range(65, 127);
            end
            else
            begin
                ws = 7'd0;
            end
            // short window so results pile up during the long hold
            if (ph == 4)
            begin
                ws = 7'd3;
            end
            set_window(ws);
            idle_on = (ph < 14);
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 10;
                2: idle_pct = 30;
                default: idle_pct = 60;
            endcase
            if (ph == 4)
            begin
                hold_trigger++;
            end
            for (i = 0; i < 100; i++)
            begin
                if (i == 0)
                begin
                    first = ($urandom_range(0, 4) != 0);
                end
                else
                begin
                    first = ($urandom_range(0, 99) < 3);
                end
                push_item(pick_sample(), first);
            end
            drain();
        end

        if (exp_wr != exp_rd)
        begin
            log_failure($sformatf("%0d results never arrived", exp_wr - exp_rd));
        end
        if (errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sliding_window_maximum.f */
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/swm_deque.sv
hdl/sliding_window_maximum.sv
hdl/swm_checker.sv
bench/sliding_window_maximum_tb.sv
